// ===== hdl/plid_pkg.sv =====
// Package: shared types, codes and default sizes for the positional list.
`timescale 1ns / 1ps
package plid_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_LIST_DEPTH = 16;
  localparam int DEF_VALUE_BITS = 32;

  // Fixed field widths of the request and result transfers
  localparam int POS_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int LEN_BITS = 5;

  // Request kinds
  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_DELETE = 1'b1
  } req_type_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_POS_ERR = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  // Per-cell update selection
  typedef enum logic [1:0] {
    CELL_HOLD      = 2'd0,
    CELL_FROM_PREV = 2'd1,
    CELL_FROM_NEXT = 2'd2,
    CELL_LOAD      = 2'd3
  } cell_op_t;

  // Request transfer payload
  typedef struct packed {
    req_type_t                    req_type;
    logic [POS_BITS-1:0]          position;
    logic signed [DATA_BITS-1:0]  new_value;
  } req_t;

  // Result transfer payload
  typedef struct packed {
    status_t                      status;
    logic signed [DATA_BITS-1:0]  removed_value;
    logic [LEN_BITS-1:0]          length_after;
  } res_t;

endpackage

// ===== hdl/plid_cell.sv =====
// One storage cell of the list: hold, shift from a neighbour or load a new value.
`timescale 1ns / 1ps
module plid_cell import plid_pkg::*; #(
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic                  clk,
  input  cell_op_t              op,
  input  logic [VALUE_BITS-1:0] prev_value,
  input  logic [VALUE_BITS-1:0] next_value,
  input  logic [VALUE_BITS-1:0] load_value,
  output logic [VALUE_BITS-1:0] value
);

  logic [VALUE_BITS-1:0] value_next;

  // Local choice of the cell's next content
  always_comb begin
    unique case (op)
      CELL_HOLD:      value_next = value;
      CELL_FROM_PREV: value_next = prev_value;
      CELL_FROM_NEXT: value_next = next_value;
      CELL_LOAD:      value_next = load_value;
      default:        value_next = value;
    endcase
  end

  // Payload register, no reset needed
  always_ff @(posedge clk) begin
    value <= value_next;
  end

endmodule

// ===== hdl/plid_list.sv =====
// List core: row of cells, entry count, range checks and result formation.
`timescale 1ns / 1ps
module plid_list import plid_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic fire,
  input  req_t req,
  output res_t res
);

  localparam int CW   = $clog2(LIST_DEPTH + 1);
  localparam int IW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CMPW = ((CW > POS_BITS) ? CW : POS_BITS) + 1;

  logic [CW-1:0]         count, count_next;
  logic [CMPW-1:0]       pos_ext, cnt_ext, pos_m1;
  logic [IW-1:0]         idx;
  logic                  ins_pos_ok, del_pos_ok, is_full, do_ins, do_del;
  logic [VALUE_BITS-1:0] load_val, rd_val;
  logic [DATA_BITS-1:0]  rd_wide;
  logic [VALUE_BITS-1:0] vals [LIST_DEPTH];
  cell_op_t              ops  [LIST_DEPTH];

  // Position checks against the current count
  assign pos_ext    = CMPW'(req.position);
  assign cnt_ext    = CMPW'(count);
  assign pos_m1     = pos_ext - CMPW'(1);
  assign idx        = pos_m1[IW-1:0];
  assign ins_pos_ok = (req.position != '0) && (pos_ext <= cnt_ext + CMPW'(1));
  assign del_pos_ok = (req.position != '0) && (pos_ext <= cnt_ext);
  assign is_full    = (count == CW'(LIST_DEPTH));
  assign do_ins     = (req.req_type == REQ_INSERT) && ins_pos_ok && !is_full;
  assign do_del     = (req.req_type == REQ_DELETE) && del_pos_ok;

  // Stored value keeps the low bits of the request value
  assign load_val = VALUE_BITS'($unsigned(req.new_value));

  // Read of the entry being removed, sign-extended or truncated to the port width
  assign rd_val = vals[idx];
  generate
    if (VALUE_BITS >= DATA_BITS) begin : g_rd_trunc
      assign rd_wide = rd_val[DATA_BITS-1:0];
    end else begin : g_rd_sext
      assign rd_wide = DATA_BITS'($signed(rd_val));
    end
  endgenerate

  // Row of cells, each told to hold, shift or load
  generate
    for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
      logic [VALUE_BITS-1:0] prev_v, next_v;

      if (i == 0) begin : g_first
        assign prev_v = load_val;
      end else begin : g_mid
        assign prev_v = vals[i-1];
      end
      if (i == LIST_DEPTH - 1) begin : g_last
        assign next_v = vals[i];
      end else begin : g_inner
        assign next_v = vals[i+1];
      end

      always_comb begin
        ops[i] = CELL_HOLD;
        if (fire && do_ins) begin
          if (CMPW'(i) > pos_m1) begin
            ops[i] = CELL_FROM_PREV;
          end else if (CMPW'(i) == pos_m1) begin
            ops[i] = CELL_LOAD;
          end
        end else if (fire && do_del && (CMPW'(i) >= pos_m1)) begin
          ops[i] = CELL_FROM_NEXT;
        end
      end

      plid_cell #(
        .VALUE_BITS(VALUE_BITS)
      ) u_cell (
        .clk       (clk),
        .op        (ops[i]),
        .prev_value(prev_v),
        .next_value(next_v),
        .load_value(load_val),
        .value     (vals[i])
      );
    end
  endgenerate

  // Entry count after this request
  always_comb begin
    count_next = count;
    if (do_ins) begin
      count_next = count + CW'(1);
    end else if (do_del) begin
      count_next = count - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (fire) begin
      count <= count_next;
    end
  end

  // Result fields
  always_comb begin
    if (req.req_type == REQ_INSERT) begin
      if (!ins_pos_ok) begin
        res.status = ST_POS_ERR;
      end else if (is_full) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_DONE;
      end
    end else begin
      res.status = del_pos_ok ? ST_DONE : ST_POS_ERR;
    end
    res.removed_value = do_del ? $signed(rd_wide) : '0;
    res.length_after  = LEN_BITS'(count_next);
  end

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// Top level: request register, list core and result register.
//
// Bounded list of signed words numbered from 1. A request transfer on the
// req channel (req_valid, req_stall, req) either inserts new_value before
// the given position or deletes the entry there; each request gives one
// result transfer on the res channel (res_valid, res_stall, res) holding
// the status, the removed value and the list length afterwards.
// A request taken into the request register passes to the result register
// once that register is free, and its result is offered from there.
// Throughput: one request per cycle while the result is not stalled;
// each cell picks hold, shift or load locally, so a whole insert or delete
// settles in one pass between the request register and the result register.
// Reset clears the entry count and both valid flags; cell contents are
// left as they are and are never read before being written.
// While res_valid and res_stall are both high the result register holds;
// one further request may wait in the request register, then req_stall rises.
`timescale 1ns / 1ps
module positional_list_insert_delete import plid_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH,
  parameter int VALUE_BITS = DEF_VALUE_BITS
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  logic held_valid;
  req_t held_req;
  logic advance, fire;
  res_t list_res;

  // Handshake: the held request moves on when the result register is free
  assign advance   = !res_valid || !res_stall;
  assign fire      = held_valid && advance;
  assign req_stall = held_valid && !advance;

  plid_list #(
    .LIST_DEPTH(LIST_DEPTH),
    .VALUE_BITS(VALUE_BITS)
  ) u_list (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .req (held_req),
    .res (list_res)
  );

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      res_valid  <= 1'b0;
    end else begin
      if (!req_stall) begin
        held_valid <= req_valid;
      end
      if (advance) begin
        res_valid <= held_valid;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      held_req <= req;
    end
    if (fire) begin
      res <= list_res;
    end
  end

endmodule

// ===== hdl/plid_checker.sv =====
// Port-level checks for the positional list, bound to the top level.
`timescale 1ns / 1ps
module plid_checker import plid_pkg::*; #(
  parameter int LIST_DEPTH = DEF_LIST_DEPTH
) (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic res_valid,
  input logic res_stall,
  input res_t res
);

  // A stalled result stays offered and unchanged
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(res))
    else $error("result changed while stalled");

  // Nothing is offered straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // Rejected requests never return a value
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status != ST_DONE) |-> res.removed_value == '0)
    else $error("rejected request returned a value");

  // A full error reports a full list
  a_full_len: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res.status == ST_FULL) |-> res.length_after == LEN_BITS'(LIST_DEPTH))
    else $error("full error with list not full");

  // With the result register empty, requests are never held off
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !req_stall)
    else $error("request stalled with empty result register");

endmodule

bind positional_list_insert_delete plid_checker #(
  .LIST_DEPTH(LIST_DEPTH)
) u_plid_checker (
  .clk      (clk),
  .rst      (rst),
  .req_stall(req_stall),
  .res_valid(res_valid),
  .res_stall(res_stall),
  .res      (res)
);
